### hw/rtl/multimode_audio_filter_macros.svh
// ----------------------------------------------------------------------------
// multimode_audio_filter assertion macros
// Shorthand for clocked implications, sampled on clk, off during rst_n.
// ----------------------------------------------------------------------------
`ifndef MULTIMODE_AUDIO_FILTER_MACROS_SVH
`define MULTIMODE_AUDIO_FILTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMAF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mmaf_pkg.sv
// ----------------------------------------------------------------------------
// mmaf_pkg
// Shared types, register codes and reset values of the multimode audio filter.
// ----------------------------------------------------------------------------
package mmaf_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int MODE_W     = 3;
  localparam int SHIFT_W    = 2;
  localparam int COEF_A_W   = 8;
  localparam int COEF_B_W   = 9;
  localparam int DELAY_W    = 13;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // Filter select; codes 5..7 are treated as off
  typedef enum logic [MODE_W-1:0] {
    MODE_OFF  = 3'd0,
    MODE_AVG  = 3'd1,
    MODE_LP   = 3'd2,
    MODE_HP   = 3'd3,
    MODE_ECHO = 3'd4
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_AVG_SHIFT  = 3'd1,
    CFG_COEF_A     = 3'd2,
    CFG_COEF_B     = 3'd3,
    CFG_ECHO_DELAY = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic [SHIFT_W-1:0]         RST_AVG_SHIFT  = 2'd1;
  localparam logic [COEF_A_W-1:0]        RST_COEF_A     = 8'd64;
  localparam logic signed [COEF_B_W-1:0] RST_COEF_B     = 9'sd64;
  localparam logic [DELAY_W-1:0]         RST_ECHO_DELAY = 13'd500;

  // Filter settings seen by the arithmetic stage
  typedef struct packed {
    mode_t                        mode;
    logic [SHIFT_W-1:0]           avg_shift;
    logic [COEF_A_W-1:0]          coef_a;
    logic signed [COEF_B_W-1:0]   coef_b;
  } filt_cfg_t;

endpackage

### hw/rtl/mmaf_if.sv
// ----------------------------------------------------------------------------
// mmaf_in_if / mmaf_out_if
// Valid/ready sample channels into and out of the multimode audio filter.
// ----------------------------------------------------------------------------
interface mmaf_in_if;
  import mmaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface mmaf_out_if;
  import mmaf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

### hw/rtl/mmaf_ram.sv
// ----------------------------------------------------------------------------
// mmaf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and read old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/mmaf_echo.sv
// ----------------------------------------------------------------------------
// mmaf_echo
// Echo ring: write and read pointers, primed flag and the sample store.
// The delayed tap is valid in the cycle after a step and holds until the next.
// ----------------------------------------------------------------------------
module mmaf_echo #(
  parameter int ECHO_DEPTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  mmaf_pkg::sample_t                   sample,
  input  logic [mmaf_pkg::DELAY_W-1:0]        echo_delay,
  output mmaf_pkg::sample_t                   tap
);
  import mmaf_pkg::*;

  localparam int IDX_W = $clog2(ECHO_DEPTH);
  localparam int LEN_W = $clog2(ECHO_DEPTH + 1);
  localparam int CMP_W = ((LEN_W > DELAY_W) ? LEN_W : DELAY_W) + 1;

  logic [CMP_W-1:0] delay_ext;
  logic [CMP_W-1:0] ring_len;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt, wr_cur;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt, rd_cur;
  logic [CMP_W-1:0] wr_inc, rd_inc;
  logic             wr_wrap;
  logic             primed_r, primed_nxt;
  logic             hit_r, fwd_r;
  sample_t          fwd_data_r;
  sample_t          ram_rdata;

  // Clamp ring length to 1..ECHO_DEPTH
  assign delay_ext = CMP_W'(echo_delay);
  always_comb begin
    if (delay_ext == '0) begin
      ring_len = CMP_W'(1);
    end else if (delay_ext > CMP_W'(ECHO_DEPTH)) begin
      ring_len = CMP_W'(ECHO_DEPTH);
    end else begin
      ring_len = delay_ext;
    end
  end

  // Write pointer: fold stale index, advance, wrap and mark primed
  assign wr_cur     = (CMP_W'(wr_idx_r) >= ring_len) ? '0 : wr_idx_r;
  assign wr_inc     = CMP_W'(wr_cur) + CMP_W'(1);
  assign wr_wrap    = (wr_inc >= ring_len);
  assign wr_idx_nxt = wr_wrap ? '0 : wr_inc[IDX_W-1:0];
  assign primed_nxt = primed_r | wr_wrap;

  // Read pointer: advances only once primed
  assign rd_cur     = (CMP_W'(rd_idx_r) >= ring_len) ? '0 : rd_idx_r;
  assign rd_inc     = CMP_W'(rd_cur) + CMP_W'(1);
  assign rd_idx_nxt = (rd_inc >= ring_len) ? '0 : rd_inc[IDX_W-1:0];

  // Pointer and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      primed_r <= 1'b0;
      hit_r    <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (step) begin
      wr_idx_r <= wr_idx_nxt;
      primed_r <= primed_nxt;
      hit_r    <= primed_nxt;
      fwd_r    <= (rd_cur == wr_cur);
      if (primed_nxt) begin
        rd_idx_r <= rd_idx_nxt;
      end
    end
  end

  // Hold the written sample for a same-entry read
  always_ff @(posedge clk) begin
    if (step) begin
      fwd_data_r <= sample;
    end
  end

  mmaf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (ECHO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (step),
    .waddr (wr_cur),
    .wdata (sample),
    .re    (step && primed_nxt),
    .raddr (rd_cur),
    .rdata (ram_rdata)
  );

  // Select delayed sample: zero until primed, bypass on collision
  assign tap = !hit_r ? '0 : (fwd_r ? fwd_data_r : ram_rdata);

endmodule

### hw/rtl/mmaf_core.sv
// ----------------------------------------------------------------------------
// mmaf_core
// Filter arithmetic and small filter state: moving-average history,
// first-order IIR feedback, echo mix, output saturation.
// ----------------------------------------------------------------------------
module mmaf_core #(
  parameter int AVG_TAPS       = 8,
  parameter int COEF_FRAC_BITS = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  mmaf_pkg::sample_t   x,
  input  mmaf_pkg::sample_t   tap,
  input  mmaf_pkg::filt_cfg_t cfg,
  output mmaf_pkg::sample_t   result
);
  import mmaf_pkg::*;

  localparam int AVG_LOG = $clog2(AVG_TAPS + 1) - 1;
  localparam int AVG_N   = 1 << AVG_LOG;
  localparam int SUM_W   = SAMPLE_W + AVG_LOG;
  localparam int ACC_W   = 27;
  localparam logic [SHIFT_W-1:0] AVG_LOG_SH = SHIFT_W'(AVG_LOG);
  localparam logic signed [ACC_W-1:0] HP_OFFSET = 27'sd128;

  function automatic sample_t sat_u8(input logic signed [ACC_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > 27'sd255) begin
      return 8'd255;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [ACC_W-1:0] v);
    if (v < -27'sd32768) begin
      return -16'sd32768;
    end else if (v > 27'sd32767) begin
      return 16'sd32767;
    end else begin
      return v[15:0];
    end
  endfunction

  // ---------------- moving average ----------------
  sample_t              hist_r   [AVG_N];
  sample_t              hist_nxt [AVG_N];
  logic [SHIFT_W-1:0]   avg_sh;
  logic [AVG_LOG:0]     taps;
  logic [SUM_W-1:0]     avg_sum;
  sample_t              avg_val;

  // Narrow window to the history length
  assign avg_sh = (cfg.avg_shift > AVG_LOG_SH) ? AVG_LOG_SH : cfg.avg_shift;
  assign taps   = (AVG_LOG + 1)'(1) << avg_sh;

  // Shift the window and add it up
  always_comb begin
    hist_nxt[0] = x;
    for (int i = 1; i < AVG_N; i++) begin
      hist_nxt[i] = (i < int'(taps)) ? hist_r[i-1] : hist_r[i];
    end
    avg_sum = '0;
    for (int i = 0; i < AVG_N; i++) begin
      if (i < int'(taps)) begin
        avg_sum = avg_sum + SUM_W'(hist_nxt[i]);
      end
    end
  end

  assign avg_val = (avg_sh == '0) ? '0 : SAMPLE_W'(avg_sum >> avg_sh);

  // Advance history only for an average beat with a real window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AVG_N; i++) begin
        hist_r[i] <= '0;
      end
    end else if (go && cfg.mode == MODE_AVG && avg_sh != '0) begin
      hist_r <= hist_nxt;
    end
  end

  // ---------------- first-order IIR ----------------
  sample_t                  xp_r;
  logic signed [15:0]       yp_r;
  logic signed [9:0]        diff;
  logic signed [8:0]        a_s;
  logic signed [18:0]       prod_a;
  logic signed [24:0]       prod_b;
  logic signed [ACC_W-1:0]  iir_acc;
  logic signed [ACC_W-1:0]  iir_y;
  logic signed [ACC_W-1:0]  hp_y;

  assign a_s  = $signed({1'b0, cfg.coef_a});
  assign diff = (cfg.mode == MODE_HP) ?
                $signed({2'b00, x}) - $signed({2'b00, xp_r}) :
                $signed({2'b00, x}) + $signed({2'b00, xp_r});

  // Feed forward and feedback products, then floor shift
  assign prod_a  = a_s * diff;
  assign prod_b  = cfg.coef_b * yp_r;
  assign iir_acc = $signed({{8{prod_a[18]}}, prod_a}) + $signed({{2{prod_b[24]}}, prod_b});
  assign iir_y   = iir_acc >>> COEF_FRAC_BITS;
  assign hp_y    = iir_y + HP_OFFSET;

  // Keep previous input and saturated output for low-pass and high-pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xp_r <= '0;
      yp_r <= '0;
    end else if (go && (cfg.mode == MODE_LP || cfg.mode == MODE_HP)) begin
      xp_r <= x;
      yp_r <= sat_s16(iir_y);
    end
  end

  // ---------------- echo mix ----------------
  logic [15:0]              prod_ax;
  logic signed [17:0]       prod_bd;
  logic signed [ACC_W-1:0]  echo_acc;
  logic signed [ACC_W-1:0]  echo_y;

  assign prod_ax  = cfg.coef_a * x;
  assign prod_bd  = cfg.coef_b * $signed({1'b0, tap});
  assign echo_acc = $signed({11'b0, prod_ax}) + $signed({{9{prod_bd[17]}}, prod_bd});
  assign echo_y   = echo_acc >>> COEF_FRAC_BITS;

  // ---------------- result select ----------------
  always_comb begin
    unique case (cfg.mode)
      MODE_AVG:  result = avg_val;
      MODE_LP:   result = sat_u8(iir_y);
      MODE_HP:   result = sat_u8(hp_y);
      MODE_ECHO: result = sat_u8(echo_y);
      default:   result = '0;
    endcase
  end

endmodule

### hw/rtl/multimode_audio_filter.sv
// ----------------------------------------------------------------------------
// multimode_audio_filter
// Four-mode 8-bit audio filter: moving average, IIR low-pass, IIR high-pass
// and echo, with saturated output.
//
//   channel   dir  payload             handshake
//   in_chan   in   sample_in  [7:0]    valid/ready
//   out_chan  out  sample_out [7:0]    valid/ready
//   cfg_*     in   cfg_addr, cfg_wdata cfg_we, no back-pressure
//
// Sustains one beat per cycle while out_chan is ready. The accepting edge
// loads stage 1 and issues the echo store read; the arithmetic then runs on
// stage 1 and loads the output register once that register frees up.
// IIR feedback closes within the arithmetic stage.
// Beats in mode off (or an unknown code) are taken and dropped, no result.
// Reset clears control and filter state at once; the echo store needs no
// clearing pass. An output stall holds the arithmetic stage; in_chan.ready
// drops in the same cycle once stage 1 holds a beat.
// ----------------------------------------------------------------------------
`include "multimode_audio_filter_macros.svh"

module multimode_audio_filter #(
  parameter int ECHO_DEPTH     = 4096,
  parameter int AVG_TAPS       = 8,
  parameter int COEF_FRAC_BITS = 7
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mmaf_in_if.sink                         in_chan,
  mmaf_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [mmaf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mmaf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mmaf_pkg::*;

  // Configuration registers
  mode_t                       mode_r;
  logic [SHIFT_W-1:0]          avg_shift_r;
  logic [COEF_A_W-1:0]         coef_a_r;
  logic signed [COEF_B_W-1:0]  coef_b_r;
  logic [DELAY_W-1:0]          echo_delay_r;

  // Pipeline control
  logic      in_ready, in_acc, mode_live, echo_step;
  logic      s1_valid_r, s1_valid_nxt, s1_go;
  sample_t   s1_x_r;
  mode_t     s1_mode_r;
  logic      out_valid_r, out_valid_nxt;
  sample_t   out_data_r;
  sample_t   tap, result;
  filt_cfg_t core_cfg;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_OFF;
      avg_shift_r  <= RST_AVG_SHIFT;
      coef_a_r     <= RST_COEF_A;
      coef_b_r     <= RST_COEF_B;
      echo_delay_r <= RST_ECHO_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE:       mode_r       <= mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_AVG_SHIFT:  avg_shift_r  <= cfg_wdata[SHIFT_W-1:0];
        CFG_COEF_A:     coef_a_r     <= cfg_wdata[COEF_A_W-1:0];
        CFG_COEF_B:     coef_b_r     <= $signed(cfg_wdata[COEF_B_W-1:0]);
        CFG_ECHO_DELAY: echo_delay_r <= cfg_wdata[DELAY_W-1:0];
        default:        ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the output register frees up
  assign mode_live = (mode_r == MODE_AVG) || (mode_r == MODE_LP) ||
                     (mode_r == MODE_HP)  || (mode_r == MODE_ECHO);
  assign s1_go     = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign in_acc    = in_chan.valid && in_ready;
  assign echo_step = in_acc && (mode_r == MODE_ECHO);

  assign in_chan.ready = in_ready;

  // Stage 1 occupancy
  always_comb begin
    if (in_acc && mode_live) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Load the stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc && mode_live) begin
      s1_x_r    <= in_chan.sample_in;
      s1_mode_r <= mode_r;
    end
  end

  mmaf_echo #(
    .ECHO_DEPTH (ECHO_DEPTH)
  ) u_echo (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (echo_step),
    .sample     (in_chan.sample_in),
    .echo_delay (echo_delay_r),
    .tap        (tap)
  );

  assign core_cfg = '{mode:      s1_mode_r,
                      avg_shift: avg_shift_r,
                      coef_a:    coef_a_r,
                      coef_b:    coef_b_r};

  mmaf_core #(
    .AVG_TAPS       (AVG_TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_go),
    .x      (s1_x_r),
    .tap    (tap),
    .cfg    (core_cfg),
    .result (result)
  );

  // Output register
  always_comb begin
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.sample_out = out_data_r;

  // Checks
  `MMAF_ASSERT_NEXT(a_off_beat_dropped, in_acc && !mode_live, !s1_valid_r, "off-mode beat staged")
  `MMAF_ASSERT_NEXT(a_live_beat_staged, in_acc && mode_live, s1_valid_r && s1_x_r == $past(in_chan.sample_in), "live beat not staged")
  `MMAF_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_chan.ready, !s1_go, "stalled result overwritten")

endmodule

### tb/tb_multimode_audio_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multimode_audio_filter
// Sends corner-case and random samples through every filter mode and random
// register settings. A scoreboard predicts each filtered sample and checks the
// output beats in order. Both channels idle at random, and registers change only
// while the filter is drained.
// ----------------------------------------------------------------------------
module tb_multimode_audio_filter;
  import mmaf_pkg::*;

  localparam int RING_DEPTH   = 4096;
  localparam int FRAC_BITS    = 7;
  localparam int HP_OFFSET    = 128;
  localparam int DRAIN_CYCLES = 6;
  localparam int TAIL_CYCLES  = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 1330;

  typedef struct {
    mode_t                mode;
    logic [SHIFT_W-1:0]   avg_shift;
    logic [COEF_A_W-1:0]  coef_a;
    logic signed [8:0]    coef_b;
    logic [DELAY_W-1:0]   echo_delay;
  } filter_setup_t;

  // Shadow of the filter state; predicts one output sample per live-mode input beat
  class audio_filter_scoreboard;
    filter_setup_t setup;
    sample_t       avg_hist[8];
    sample_t       iir_prev_in;
    int            iir_prev_out;
    sample_t       echo_ring[RING_DEPTH];
    int            echo_wr;
    int            echo_rd;
    bit            echo_primed;
    int            echo_filled;
    sample_t       expected_samples[$];
    int            mismatch_count;

    function new();
      setup.mode       = MODE_OFF;
      setup.avg_shift  = RST_AVG_SHIFT;
      setup.coef_a     = RST_COEF_A;
      setup.coef_b     = RST_COEF_B;
      setup.echo_delay = RST_ECHO_DELAY;
      foreach (avg_hist[i]) avg_hist[i] = '0;
      iir_prev_in    = '0;
      iir_prev_out   = 0;
      echo_wr        = 0;
      echo_rd        = 0;
      echo_primed    = 1'b0;
      echo_filled    = 0;
      mismatch_count = 0;
    endfunction

    function sample_t sat_u8(longint v);
      if (v < 0) return 8'h00;
      if (v > 255) return 8'hFF;
      return sample_t'(v);
    endfunction

    // Shift only the active window, then average it
    function sample_t run_average(sample_t x);
      int sh;
      int sum;
      sh  = setup.avg_shift;
      sum = 0;
      if (sh == 0) return 8'h00;
      for (int i = (1 << sh) - 1; i > 0; i--) avg_hist[i] = avg_hist[i-1];
      avg_hist[0] = x;
      for (int i = 0; i < (1 << sh); i++) sum += avg_hist[i];
      return sample_t'(sum >> sh);
    endfunction

    // Low-pass sums the last two inputs, high-pass takes their difference
    function sample_t run_iir(sample_t x, bit high);
      longint diff;
      longint y;
      diff = high ? longint'(x) - longint'(iir_prev_in)
                  : longint'(x) + longint'(iir_prev_in);
      y = (longint'(setup.coef_a) * diff
           + longint'(setup.coef_b) * longint'(iir_prev_out)) >>> FRAC_BITS;
      iir_prev_in  = x;
      iir_prev_out = (y < -32768) ? -32768 : (y > 32767) ? 32767 : int'(y);
      return high ? sat_u8(y + HP_OFFSET) : sat_u8(y);
    endfunction

    // Write the ring, then read the delayed tap once the ring has wrapped
    function sample_t run_echo(sample_t x);
      int     len;
      longint tap;
      len = int'(setup.echo_delay);
      tap = 0;
      if (len == 0) len = 1;
      if (len > RING_DEPTH) len = RING_DEPTH;
      if (echo_wr >= len) echo_wr = 0;
      echo_ring[echo_wr] = x;
      echo_wr++;
      if (echo_wr > echo_filled) echo_filled = echo_wr;
      if (echo_wr >= len) begin
        echo_wr     = 0;
        echo_primed = 1'b1;
      end
      if (echo_primed) begin
        if (echo_rd >= len) echo_rd = 0;
        tap = longint'(echo_ring[echo_rd]);
        echo_rd++;
        if (echo_rd >= len) echo_rd = 0;
      end
      return sat_u8((longint'(setup.coef_a) * longint'(x)
                     + longint'(setup.coef_b) * tap) >>> FRAC_BITS);
    endfunction

    function void take_sample(sample_t x);
      case (setup.mode)
        MODE_AVG:  expected_samples.push_back(run_average(x));
        MODE_LP:   expected_samples.push_back(run_iir(x, 1'b0));
        MODE_HP:   expected_samples.push_back(run_iir(x, 1'b1));
        MODE_ECHO: expected_samples.push_back(run_echo(x));
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    task check_sample(sample_t y);
      sample_t want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample_out %0d with no result pending", y));
        return;
      end
      want = expected_samples.pop_front();
      if (y !== want)
        report_mismatch($sformatf("sample_out %0d, predicted %0d", y, want));
    endtask

    function int pending_count();
      return expected_samples.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    send_idle_pct = 22;
  int                    stall_pct = 62;
  int                    quiet_cycles = 0;

  audio_filter_scoreboard sb = new();

  mmaf_in_if  in_if ();
  mmaf_out_if out_if ();

  multimode_audio_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Stall the output channel at random
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watch both channels; feed accepted beats to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (in_if.valid && in_if.ready) sb.take_sample(in_if.sample_in);
      if (out_if.valid && out_if.ready) sb.check_sample(out_if.sample_out);
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("multimode_audio_filter test failed");
    $finish;
  end

  // Offer one sample, with random idle cycles first; return on acceptance
  task automatic send_sample(sample_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= x;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Drop valid, let the monitor note the last beat, wait for every predicted
  // sample, then let the pipe empty
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_setup(filter_setup_t s);
    write_reg(CFG_MODE, CFG_DATA_W'(s.mode));
    write_reg(CFG_AVG_SHIFT, CFG_DATA_W'(s.avg_shift));
    write_reg(CFG_COEF_A, CFG_DATA_W'(s.coef_a));
    write_reg(CFG_COEF_B, {4'd0, s.coef_b});
    write_reg(CFG_ECHO_DELAY, s.echo_delay);
    cfg_we    <= 1'b0;
    sb.setup = s;
  endtask

  function automatic sample_t next_sample(sample_t prev);
    case ($urandom_range(9))
      0, 1:    return prev;
      2:       return 8'h00;
      3:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Pick a register set; once the echo ring has wrapped, never lengthen it
  // past the entries already written
  function automatic filter_setup_t random_setup(bit primed, int filled);
    filter_setup_t s;
    int            r;
    r = $urandom_range(19);
    if (r == 0) s.mode = ($urandom_range(1) == 0) ? MODE_OFF : mode_t'(3'($urandom_range(7, 5)));
    else s.mode = mode_t'(3'(1 + r % 4));
    s.avg_shift = 2'($urandom_range(3));
    case ($urandom_range(5))
      0:       s.coef_a = 8'd0;
      1:       s.coef_a = 8'd128;
      2:       s.coef_a = 8'd255;
      default: s.coef_a = 8'($urandom_range(255));
    endcase
    case ($urandom_range(7))
      0:       s.coef_b = 9'sh100;
      1:       s.coef_b = 9'sh180;
      2:       s.coef_b = 9'sd0;
      3:       s.coef_b = 9'sd128;
      4:       s.coef_b = 9'sd255;
      default: s.coef_b = 9'($urandom_range(511));
    endcase
    if (!primed) s.echo_delay = 13'($urandom_range(256, 64));
    else begin
      case ($urandom_range(7))
        0:       s.echo_delay = 13'd0;
        1:       s.echo_delay = 13'd1;
        2:       s.echo_delay = 13'(filled);
        default: s.echo_delay = 13'($urandom_range((filled < 64) ? filled : 64, 1));
      endcase
    end
    return s;
  endfunction

  initial begin : stimulus
    filter_setup_t s;
    sample_t       last;
    int            counted;
    int            n;
    bit            active;

    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Mode off after reset: beats are dropped
    send_sample(8'hFF);
    send_sample(8'h00);

    // Zero window shift gives zero and leaves the history alone
    settle();
    apply_setup('{MODE_AVG, 2'd0, 8'd64, 9'sd64, 13'd4096});
    send_sample(8'hFF);
    send_sample(8'h81);

    // Widest window: ramp up from zero history, then drop
    settle();
    apply_setup('{MODE_AVG, 2'd3, 8'd64, 9'sd64, 13'd4096});
    repeat (4) send_sample(8'hFF);
    send_sample(8'h00);

    // Unknown mode code: dropped like off
    settle();
    apply_setup('{mode_t'(3'd7), 2'd3, 8'd64, 9'sd64, 13'd4096});
    send_sample(8'hA5);

    // Low-pass with largest feedback gain: drive into saturation
    settle();
    apply_setup('{MODE_LP, 2'd1, 8'd128, 9'sd255, 13'd4096});
    repeat (3) send_sample(8'hFF);

    // High-pass with most negative feedback: both clamp directions
    settle();
    apply_setup('{MODE_HP, 2'd1, 8'd255, 9'sh100, 13'd4096});
    send_sample(8'h00);
    send_sample(8'hFF);
    send_sample(8'h00);
    send_sample(8'h80);

    // Echo with a ring length past the store depth, not yet wrapped
    settle();
    apply_setup('{MODE_ECHO, 2'd1, 8'd255, 9'sd255, 13'd8191});
    send_sample(8'hFF);
    send_sample(8'h00);
    send_sample(8'h7F);

    // Random phases; the first echo phase runs long enough to wrap the ring
    counted = 0;
    last    = '0;
    while (counted < RANDOM_ITEMS) begin
      settle();
      s = random_setup(sb.echo_primed, sb.echo_filled);
      apply_setup(s);
      active = s.mode inside {MODE_AVG, MODE_LP, MODE_HP, MODE_ECHO};
      if (!active) n = $urandom_range(10, 4);
      else if (s.mode == MODE_ECHO && !sb.echo_primed)
        n = int'(s.echo_delay) + $urandom_range(60, 20);
      else n = $urandom_range(80, 20);
      repeat (n) begin
        if (counted < RANDOM_ITEMS / 3) begin
          send_idle_pct = 22;
          stall_pct     = 62;
        end else if (counted < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 62;
          stall_pct     = 22;
        end else begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        last = next_sample(last);
        send_sample(last);
        if (active) counted++;
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) $display("multimode_audio_filter test passed");
    else $display("multimode_audio_filter test failed");
    $finish;
  end

endmodule

### multimode_audio_filter.f
+incdir+hw/rtl
hw/rtl/mmaf_pkg.sv
hw/rtl/mmaf_if.sv
hw/rtl/mmaf_ram.sv
hw/rtl/mmaf_echo.sv
hw/rtl/mmaf_core.sv
hw/rtl/multimode_audio_filter.sv
tb/tb_multimode_audio_filter.sv
